// ===== src/ssf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the case-folding function for the substring search block.
// Used by every module under src; depends on nothing else.
package ssf_pkg;

	localparam int NEEDLE_MAX_DEF    = 32;
	localparam int POSITION_BITS_DEF = 32;

	localparam int CHAR_W      = 8;
	localparam int NIDX_W      = 5;
	localparam int OFFSET_W    = 32;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 6;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 32;

	localparam logic [CHAR_W-1:0] LOWER_A   = 8'd97;
	localparam logic [CHAR_W-1:0] LOWER_Z   = 8'd122;
	localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NEEDLE_LENGTH = 1'b0,
		REG_CASE_FOLD     = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		CMD_LOAD     = 1'b0,
		CMD_HAYSTACK = 1'b1
	} cmd_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic              hay_en;
		logic              clear;
		logic              fold;
		logic [CHAR_W-1:0] ch;
	} cell_ctrl_t;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} result_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
			input logic fold);
		if (fold && c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_DIFF;
		end
		return c;
	endfunction

endpackage

// ===== src/ssf_cell.sv =====
`timescale 1ns / 1ps
// One cell of the matching row: holds one needle byte and one prefix-match bit.
// Depends on ssf_pkg.
module ssf_cell
	import ssf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic              load_en,
	input  logic              prev_bit,
	output logic              bit_next,
	output logic              bit_q
);

	logic [CHAR_W-1:0] needle_q;

	// The prefix ending here extends the one held by the left-hand neighbour.
	assign bit_next = prev_bit &&
		(fold_char(ctrl.ch, ctrl.fold) == fold_char(needle_q, ctrl.fold));

	always_ff @(posedge clk) begin
		if (load_en) begin
			needle_q <= ctrl.ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.hay_en) begin
			bit_q <= ctrl.clear ? 1'b0 : bit_next;
		end
	end

endmodule

// ===== src/ssf_tracker.sv =====
`timescale 1ns / 1ps
// Byte position counter and first-match bookkeeping for the substring search.
// Depends on ssf_pkg.
module ssf_tracker
	import ssf_pkg::*;
#(
	parameter int NEEDLE_MAX    = NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF,
	localparam int LEN_W        = $clog2(NEEDLE_MAX + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hay_en,
	input  logic             last,
	input  logic             hit,
	input  logic [LEN_W-1:0] len_m1,
	output result_t          result
);

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] first_q;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] len_m1_p;
	logic [POSITION_BITS-1:0] start_pos;

	assign len_m1_p  = POSITION_BITS'(len_m1);
	assign start_pos = (pos_q >= len_m1_p) ? pos_q - len_m1_p : '0;

	always_comb begin
		result.found  = seen_q || hit;
		result.offset = '0;
		if (seen_q) begin
			result.offset = OFFSET_W'(first_q);
		end else if (hit) begin
			result.offset = OFFSET_W'(start_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			seen_q  <= 1'b0;
			first_q <= '0;
		end else if (hay_en) begin
			if (last) begin
				pos_q   <= '0;
				seen_q  <= 1'b0;
				first_q <= '0;
			end else begin
				// The counter sticks at its all-ones value.
				if (pos_q != '1) begin
					pos_q <= pos_q + 1'b1;
				end
				if (hit && !seen_q) begin
					seen_q  <= 1'b1;
					first_q <= start_pos;
				end
			end
		end
	end

endmodule

// ===== src/substring_search_case_fold.sv =====
`timescale 1ns / 1ps
// Top level of the streaming substring search with optional ASCII case folding.
// Depends on ssf_pkg, ssf_cell and ssf_tracker.
//
// Usage: write needle_length (index 0) and case_fold (index 1) on the cfg channel
// while the block is idle; cfg_ready is always high. Load the needle with slave
// requests whose tuser is 0, one byte per request at its index. Then stream the
// haystack with tuser 1, one byte per request, and mark the final byte with tlast.
// That final request produces one master request: tuser is found, tdata is the
// offset of the earliest match start (zero when not found).
// Throughput is one byte per cycle unless a held result stalls on the master side:
// every cell of the row compares its needle byte with the broadcast haystack byte
// and passes its prefix bit on. The result appears on the master side in the cycle
// after the last byte is taken. A single output register parts the sides; s_tready
// drops only while a result is held and the master side stalls. Reset clears the
// match row, the position counter, the output valid flag and both configuration
// registers; the held result data and the needle bytes hold no reset value, and the
// needle must be loaded before use.
module substring_search_case_fold
	import ssf_pkg::*;
#(
	parameter int NEEDLE_MAX    = NEEDLE_MAX_DEF,
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [S_TDATA_W-1:0]   s_tdata,  // char_value[7:0], needle_index[12:8], zero fill
	input  logic                   s_tuser,  // cmd
	input  logic                   s_tlast,  // is_last
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [M_TDATA_W-1:0]   m_tdata,  // match_offset[31:0]
	output logic                   m_tuser,  // found
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
	localparam int SEL_W = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

	logic [CFG_DATA_W-1:0] needle_length_q;
	logic                  case_fold_q;
	logic                  m_tvalid_q;
	result_t               result_q;

	logic                  s_acc;
	logic                  hay_acc;
	logic                  load_acc;
	logic [NIDX_W-1:0]     nidx;
	cell_ctrl_t            ctrl;
	logic [NEEDLE_MAX-1:0] bits_q;
	logic [NEEDLE_MAX-1:0] bits_next;
	logic [LEN_W-1:0]      len;
	logic [LEN_W-1:0]      len_m1;
	logic                  hit;
	result_t               result;

	assign cfg_ready = 1'b1;
	assign s_tready  = !m_tvalid_q || m_tready;
	assign s_acc     = s_tvalid && s_tready;
	assign hay_acc   = s_acc && (s_tuser == CMD_HAYSTACK);
	assign load_acc  = s_acc && (s_tuser == CMD_LOAD);
	assign nidx      = s_tdata[CHAR_W +: NIDX_W];

	assign ctrl.hay_en = hay_acc;
	assign ctrl.clear  = s_tlast;
	assign ctrl.fold   = case_fold_q;
	assign ctrl.ch     = s_tdata[CHAR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_length_q <= '0;
			case_fold_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_NEEDLE_LENGTH: needle_length_q <= cfg_data;
				REG_CASE_FOLD:     case_fold_q     <= cfg_data[0];
			endcase
		end
	end

	// Lengths beyond the row saturate to its size.
	always_comb begin
		if (int'(needle_length_q) > NEEDLE_MAX) begin
			len = LEN_W'(NEEDLE_MAX);
		end else begin
			len = LEN_W'(needle_length_q);
		end
	end

	assign len_m1 = len - 1'b1;
	assign hit    = (len != '0) && bits_next[len_m1[SEL_W-1:0]];

	genvar k;
	generate
		for (k = 0; k < NEEDLE_MAX; k++) begin : g_cell
			logic prev_bit;
			if (k == 0) begin : g_head
				assign prev_bit = 1'b1;
			end else begin : g_body
				assign prev_bit = bits_q[k-1];
			end
			ssf_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.load_en  (load_acc && (int'(nidx) == k)),
				.prev_bit (prev_bit),
				.bit_next (bits_next[k]),
				.bit_q    (bits_q[k])
			);
		end
	endgenerate

	ssf_tracker #(
		.NEEDLE_MAX    (NEEDLE_MAX),
		.POSITION_BITS (POSITION_BITS)
	) u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.hay_en (hay_acc),
		.last   (s_tlast),
		.hit    (hit),
		.len_m1 (len_m1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (hay_acc && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hay_acc && s_tlast) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = result_q.found;
	assign m_tdata  = result_q.offset;

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser && s_tlast))
		else $error("result request without a final haystack byte");

	a_offset_zero_when_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("non-zero offset reported for a missing needle");

	a_row_cleared_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(hay_acc && s_tlast) |=> (bits_q == '0))
		else $error("match row not cleared after the final haystack byte");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while a stalled result occupies the output");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for substring_search_case_fold: needle loads and haystack streams go in,
// and each verdict that comes out is checked against a cycle-free shift-and search kept here.
// Depends on ssf_pkg and the RTL under src.
module tb_top;
	import ssf_pkg::*;

	localparam int NMAX = NEEDLE_MAX_DEF;

	typedef struct {
		cmd_t              cmd;
		logic [CHAR_W-1:0] ch;
		logic [NIDX_W-1:0] idx;
		logic              last;
	} stream_req_t;

	typedef struct {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;  // char_value[7:0], needle_index[12:8], zero fill
	logic                   s_tuser = 1'b0;  // cmd
	logic                   s_tlast = 1'b0;  // is_last
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;  // match_offset[31:0]
	logic                   m_tuser;  // found
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_NEEDLE_LENGTH;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Search state as the block should hold it.
	logic [CHAR_W-1:0]   needle_mem [NMAX] = '{default: '0};
	logic [NMAX-1:0]     prefix_vec = '0;
	logic [OFFSET_W-1:0] byte_pos = '0;
	logic                hit_seen = 1'b0;
	logic [OFFSET_W-1:0] hit_off = '0;
	logic [5:0]          len_reg = '0;
	logic                fold_reg = 1'b0;

	stream_req_t req_q[$];
	verdict_t    verdict_q[$];
	int unsigned queued_cnt = 0;
	int unsigned taken_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned tx_mode = 0;
	int unsigned rx_mode = 0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;
	logic        rx_hold = 1'b0;
	logic        pressure_go = 1'b0;
	logic        pressure_done = 1'b0;

	substring_search_case_fold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [CHAR_W-1:0] upcase(input logic [CHAR_W-1:0] b, input logic en);
		if (en && b >= LOWER_A && b <= LOWER_Z) begin
			return b & 8'hDF;
		end
		return b;
	endfunction

	// Advances the search by one accepted request and queues a verdict on the final byte.
	function automatic void step_search(input logic cmd, input logic [CHAR_W-1:0] ch,
			input logic [NIDX_W-1:0] idx, input logic last);
		int unsigned eff;
		logic [CHAR_W-1:0] h;
		verdict_t v;
		if (cmd == CMD_LOAD) begin
			needle_mem[idx] = ch;
			return;
		end
		eff = (len_reg > NMAX) ? NMAX : len_reg;
		h = upcase(ch, fold_reg);
		for (int k = NMAX - 1; k > 0; k--) begin
			prefix_vec[k] = prefix_vec[k-1] && (h == upcase(needle_mem[k], fold_reg));
		end
		prefix_vec[0] = (h == upcase(needle_mem[0], fold_reg));
		if (eff != 0 && !hit_seen && prefix_vec[eff-1]) begin
			hit_seen = 1'b1;
			hit_off = (byte_pos >= eff - 1) ? byte_pos - (eff - 1) : '0;
		end
		if (byte_pos != '1) begin
			byte_pos++;
		end
		if (last) begin
			v.found = hit_seen;
			v.offset = hit_seen ? hit_off : '0;
			verdict_q.push_back(v);
			prefix_vec = '0;
			byte_pos = '0;
			hit_seen = 1'b0;
			hit_off = '0;
		end
	endfunction

	function automatic int unsigned draw_wait(input int unsigned mode);
		case (mode)
			0: return 0;
			1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			default: return $urandom_range(0, 16);
		endcase
	endfunction

	// Mostly bytes near the case boundaries, so that folding decides the outcome.
	function automatic logic [CHAR_W-1:0] pick_byte();
		case ($urandom_range(0, 12))
			0: return "a";
			1: return "A";
			2: return "b";
			3: return "B";
			4: return "z";
			5: return "Z";
			6: return "@";
			7: return 8'h60;
			8: return "[";
			9: return "{";
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] vary_case(input logic [CHAR_W-1:0] b, input logic en);
		if (en && $urandom_range(0, 1) == 1 &&
				((b >= "A" && b <= "Z") || (b >= LOWER_A && b <= LOWER_Z))) begin
			return b ^ CASE_DIFF;
		end
		return b;
	endfunction

	function automatic void push_load(input logic [NIDX_W-1:0] idx, input logic [CHAR_W-1:0] ch,
			input logic last);
		stream_req_t r;
		r.cmd = CMD_LOAD;
		r.ch = ch;
		r.idx = idx;
		r.last = last;
		req_q.push_back(r);
		queued_cnt++;
	endfunction

	function automatic void push_hay(input logic [CHAR_W-1:0] ch, input logic last);
		stream_req_t r;
		r.cmd = CMD_HAYSTACK;
		r.ch = ch;
		r.idx = NIDX_W'($urandom_range(0, NMAX - 1));
		r.last = last;
		req_q.push_back(r);
		queued_cnt++;
	endfunction

	// Returns at a rising edge once every request is taken and every verdict has arrived,
	// plus a short pause so that a trailing needle load has settled.
	task automatic wait_idle();
		while (taken_cnt != queued_cnt || verdict_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == REG_NEEDLE_LENGTH) begin
			len_reg = val;
		end else begin
			fold_reg = val[0];
		end
		@(posedge clk);
	endtask

	// One setting, a fresh needle and a few haystacks, some with a copy of the needle inside.
	task automatic random_phase();
		int unsigned len_cfg;
		int unsigned eff;
		int unsigned hay_len;
		int unsigned at;
		logic fold;
		logic [CHAR_W-1:0] pat [NMAX];
		logic [CHAR_W-1:0] b;
		case ($urandom_range(0, 9))
			0: len_cfg = 0;
			1: len_cfg = $urandom_range(NMAX + 1, 63);
			2: len_cfg = NMAX;
			3, 4: len_cfg = $urandom_range(9, NMAX - 1);
			default: len_cfg = $urandom_range(1, 8);
		endcase
		fold = 1'($urandom_range(0, 1));
		tx_mode = $urandom_range(0, 2);
		rx_mode = $urandom_range(0, 2);
		write_reg(REG_NEEDLE_LENGTH, CFG_DATA_W'(len_cfg));
		write_reg(REG_CASE_FOLD, {5'($urandom_range(0, 31)), fold});
		eff = (len_cfg > NMAX) ? NMAX : len_cfg;
		for (int k = 0; k < eff; k++) begin
			pat[k] = pick_byte();
			push_load(NIDX_W'(k), pat[k], $urandom_range(0, 7) == 0);
		end
		repeat ($urandom_range(1, 5)) begin
			hay_len = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, eff * 2 + 6);
			at = ($urandom_range(0, 2) != 0 && hay_len >= eff)
				? $urandom_range(0, hay_len - eff) : hay_len;
			for (int k = 0; k < hay_len; k++) begin
				b = (k >= at && k < at + eff) ? vary_case(pat[k-at], fold) : pick_byte();
				push_hay(b, k == hay_len - 1);
				if ($urandom_range(0, 40) == 0) begin
					push_load(NIDX_W'($urandom_range(0, NMAX - 1)), pick_byte(),
						1'($urandom_range(0, 1)));
				end
			end
		end
		wait_idle();
	endtask

	// Sender: offers the next queued request after its drawn gap.
	always @(posedge clk or negedge arst_n) begin
		stream_req_t r;
		int unsigned gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			tx_wait <= 0;
		end else if (!s_tvalid || s_tready) begin
			gap = s_tvalid ? draw_wait(tx_mode) : tx_wait;
			if (gap == 0 && req_q.size() != 0) begin
				r = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= r.cmd;
				s_tdata <= {3'b000, r.idx, r.ch};
				s_tlast <= r.last;
				tx_wait <= 0;
			end else begin
				s_tvalid <= 1'b0;
				tx_wait <= (gap > 0) ? gap - 1 : 0;
			end
		end
	end

	// Receiver: predicts on every accepted request, checks every accepted verdict.
	always @(posedge clk or negedge arst_n) begin
		verdict_t want;
		int unsigned w;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken_cnt++;
				step_search(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tlast);
			end
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					err_cnt++;
					$display("%0t: verdict with none expected: found %0b offset %0d",
						$time, m_tuser, m_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (m_tuser !== want.found) begin
						err_cnt++;
						$display("%0t: found expected %0b actual %0b", $time, want.found, m_tuser);
					end
					if (m_tdata !== want.offset) begin
						err_cnt++;
						$display("%0t: match_offset expected %0d actual %0d",
							$time, want.offset, m_tdata);
					end
				end
			end
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (m_tvalid && m_tready) begin
				w = draw_wait(rx_mode);
				m_tready <= (w == 0);
				rx_wait <= w;
			end else if (rx_wait > 0) begin
				rx_wait <= rx_wait - 1;
				m_tready <= (rx_wait == 1);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Long receiver hold-off, so that a held verdict backs the input up.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
		pressure_done = 1'b1;
	end

	initial begin
		#(64'd10_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int unsigned base;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every needle entry is written once so that no compare ever sees an unwritten byte.
		tx_mode = 2;
		rx_mode = 2;
		for (int i = 0; i < NMAX; i++) begin
			push_load(NIDX_W'(i), CHAR_W'($urandom_range(0, 255)), 1'b0);
		end
		wait_idle();

		// A zero-length needle never matches.
		write_reg(REG_NEEDLE_LENGTH, 6'd0);
		write_reg(REG_CASE_FOLD, 6'd0);
		push_hay("A", 1'b1);
		wait_idle();

		// Exact compare with the extreme byte values; the last mark on a load is ignored.
		write_reg(REG_NEEDLE_LENGTH, 6'd3);
		push_load(5'd0, "a", 1'b0);
		push_load(5'd1, 8'h00, 1'b0);
		push_load(5'd2, 8'hFF, 1'b1);
		push_hay("A", 1'b0);
		push_hay(8'h00, 1'b0);
		push_hay(8'hFF, 1'b0);
		push_hay("a", 1'b0);
		push_hay(8'h00, 1'b0);
		push_hay(8'hFF, 1'b1);
		// A haystack shorter than the needle.
		push_hay("a", 1'b0);
		push_hay(8'h00, 1'b1);
		wait_idle();

		// Folding touches only a-z; the needle is rewritten while a haystack is running.
		write_reg(REG_CASE_FOLD, 6'd1);
		push_hay("{", 1'b0);
		push_hay(8'h60, 1'b0);
		push_hay("A", 1'b0);
		push_hay(8'h00, 1'b0);
		push_load(5'd2, "Z", 1'b0);
		push_hay("z", 1'b1);
		wait_idle();

		write_reg(REG_NEEDLE_LENGTH, 6'd1);
		push_hay("@", 1'b0);
		push_hay("B", 1'b0);
		push_hay("a", 1'b1);
		wait_idle();

		// Back-to-back short haystacks while the receiver holds off.
		write_reg(REG_NEEDLE_LENGTH, 6'd2);
		tx_mode = 0;
		pressure_go = 1'b1;
		wait (rx_hold);
		repeat (14) begin
			push_hay(pick_byte(), 1'b0);
			push_hay(pick_byte(), 1'b1);
		end
		wait (pressure_done);
		wait_idle();

		base = queued_cnt;
		while (queued_cnt - base < 950) begin
			random_phase();
		end

		if (err_cnt == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
